### hdl/auto_crop_border_box_defines.svh
// Assertion macros shared by the auto-crop border box RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef AUTO_CROP_BORDER_BOX_DEFINES_SVH
`define AUTO_CROP_BORDER_BOX_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/acbb_pkg.sv
// Package for the auto-crop border box: widths, register codes, queue entry types.
// No dependencies; used by every module of the block.
package acbb_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CNT_W      = 12;
  localparam int DIM_W      = 13;
  localparam int MAX_DIM    = 4096;
  localparam int Q_DEPTH    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMG_WIDTH  = 2'd0,
    REG_IMG_HEIGHT = 2'd1
  } cfg_reg_t;

  // One classified pixel handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             diff;
    logic             last;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } evt_t;

  // Running content box
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] minc;
    logic [CNT_W-1:0] maxc;
    logic [CNT_W-1:0] minr;
    logic [CNT_W-1:0] maxr;
  } box_t;

  // Finished frame waiting for result formatting
  typedef struct packed {
    box_t             box;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } snap_t;

  // Clamp a programmed dimension into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

### hdl/acbb_front.sv
// Front end: accepts pixels, tracks raster position and background, classifies each pixel.
// Depends on acbb_pkg; feeds acbb_fifo.
module acbb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [acbb_pkg::PIX_W-1:0]    pix,
  input  logic [acbb_pkg::DIM_W-1:0]    w_eff,
  input  logic [acbb_pkg::DIM_W-1:0]    h_eff,
  input  logic                          q_full,
  output logic                          q_push,
  output acbb_pkg::evt_t                q_evt
);
  import acbb_pkg::*;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] bg_r, bg_nxt;
  logic             first;
  logic             last_col;
  logic             last_row;
  logic [DIM_W-1:0] col_p1;
  logic [DIM_W-1:0] row_p1;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify the current pixel against the background
  always_comb begin
    first    = (col_r == '0) && (row_r == '0);
    col_p1   = {1'b0, col_r} + DIM_W'(1);
    row_p1   = {1'b0, row_r} + DIM_W'(1);
    last_col = col_p1 >= w_eff;
    last_row = row_p1 >= h_eff;
    bg_nxt   = first ? pix : bg_r;

    q_evt.col  = col_r;
    q_evt.row  = row_r;
    q_evt.diff = (pix != bg_nxt);
    q_evt.last = last_col && last_row;
    q_evt.w    = w_eff;
    q_evt.h    = h_eff;

    // Advance raster position; wrap at frame end
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col && last_row) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (last_col) begin
      col_nxt = '0;
      row_nxt = row_p1[CNT_W-1:0];
    end else begin
      col_nxt = col_p1[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      bg_r  <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      bg_r  <= bg_nxt;
    end
  end

endmodule

### hdl/acbb_fifo.sv
// Short queue of classified pixels between front and back ends.
// Depends on acbb_pkg for the entry type.
module acbb_fifo #(
  parameter int DEPTH = acbb_pkg::Q_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  acbb_pkg::evt_t push_evt,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output acbb_pkg::evt_t head_evt
);
  import acbb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  evt_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_evt   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_evt;
    end
  end

endmodule

### hdl/acbb_back.sv
// Back end: folds classified pixels into the content box and formats one result per frame.
// Depends on acbb_pkg and auto_crop_border_box_defines.svh; fed by acbb_fifo.
`include "auto_crop_border_box_defines.svh"
module acbb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  acbb_pkg::evt_t               head_evt,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [acbb_pkg::CNT_W-1:0]   out_left,
  output logic [acbb_pkg::CNT_W-1:0]   out_top,
  output logic [acbb_pkg::DIM_W-1:0]   out_cw,
  output logic [acbb_pkg::DIM_W-1:0]   out_ch,
  output logic                         out_status
);
  import acbb_pkg::*;

  box_t             box_r, box_nxt, box_upd;
  snap_t            snap_r;
  logic             snap_v_r, snap_v_nxt;
  logic             out_v_r, out_v_nxt;
  logic [CNT_W-1:0] left_r, top_r;
  logic [DIM_W-1:0] cw_r, ch_r;
  logic             st_r;
  logic             out_free;
  logic             snap_adv;
  logic             snap_free;
  logic             frame_end;
  logic [DIM_W-1:0] cw_c, ch_c;
  logic             st_c;

  // Handshake between box, snapshot and output register
  always_comb begin
    out_free  = !out_v_r || out_tready;
    snap_adv  = snap_v_r && out_free;
    snap_free = !snap_v_r || snap_adv;
    pop       = head_valid && (!head_evt.last || snap_free);
    frame_end = pop && head_evt.last;

    snap_v_nxt = snap_v_r;
    if (frame_end) begin
      snap_v_nxt = 1'b1;
    end else if (snap_adv) begin
      snap_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (snap_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Fold the popped pixel into the box
  always_comb begin
    box_upd = box_r;
    if (head_evt.diff) begin
      if (!box_r.found) begin
        box_upd.found = 1'b1;
        box_upd.minc  = head_evt.col;
        box_upd.maxc  = head_evt.col;
        box_upd.minr  = head_evt.row;
        box_upd.maxr  = head_evt.row;
      end else begin
        if (head_evt.col < box_r.minc) box_upd.minc = head_evt.col;
        if (head_evt.col > box_r.maxc) box_upd.maxc = head_evt.col;
        if (head_evt.row < box_r.minr) box_upd.minr = head_evt.row;
        if (head_evt.row > box_r.maxr) box_upd.maxr = head_evt.row;
      end
    end

    box_nxt = box_r;
    if (frame_end) begin
      box_nxt.found = 1'b0;
      box_nxt.minc  = '1;
      box_nxt.maxc  = '0;
      box_nxt.minr  = '1;
      box_nxt.maxr  = '0;
    end else if (pop) begin
      box_nxt = box_upd;
    end
  end

  // Size and status of the finished box
  always_comb begin
    cw_c = {1'b0, snap_r.box.maxc} - {1'b0, snap_r.box.minc} + DIM_W'(1);
    ch_c = {1'b0, snap_r.box.maxr} - {1'b0, snap_r.box.minr} + DIM_W'(1);
    st_c = !snap_r.box.found || (cw_c >= snap_r.w) || (ch_c >= snap_r.h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.found <= 1'b0;
      box_r.minc  <= '1;
      box_r.maxc  <= '0;
      box_r.minr  <= '1;
      box_r.maxr  <= '0;
      snap_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      box_r    <= box_nxt;
      snap_v_r <= snap_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Capture the frame's box on its last pixel
  always_ff @(posedge clk) begin
    if (frame_end) begin
      snap_r.box <= box_upd;
      snap_r.w   <= head_evt.w;
      snap_r.h   <= head_evt.h;
    end
  end

  // Load the result register; an empty frame reports zeros
  always_ff @(posedge clk) begin
    if (snap_adv) begin
      left_r <= snap_r.box.found ? snap_r.box.minc : '0;
      top_r  <= snap_r.box.found ? snap_r.box.minr : '0;
      cw_r   <= snap_r.box.found ? cw_c : '0;
      ch_r   <= snap_r.box.found ? ch_c : '0;
      st_r   <= st_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_left   = left_r;
  assign out_top    = top_r;
  assign out_cw     = cw_r;
  assign out_ch     = ch_r;
  assign out_status = st_r;

  `ACBB_ASSERT_NOW(a_box_ordered, box_r.found, (box_r.minc <= box_r.maxc) && (box_r.minr <= box_r.maxr), "content box corners out of order")
  `ACBB_ASSERT_NEXT(a_frame_end_snap, frame_end, snap_v_r, "frame end did not load snapshot")
  `ACBB_ASSERT_NOW(a_valid_crop_size, out_v_r && !st_r, (cw_r != '0) && (ch_r != '0), "valid crop with zero size")

endmodule

### hdl/auto_crop_border_box.sv
// Auto-crop border box finder.
// Pixels enter on in_* in raster order, one per accepted transaction, red in the low
// byte of in_tdata. The frame is img_width by img_height pixels, set through the cfg_*
// write channel (index 0 width, index 1 height; the low 13 bits of cfg_data are kept,
// 0 is taken as 1, values above 4096 as 4096). cfg_ready is always high.
// The first pixel of a frame becomes the background. After the last pixel of a frame
// one result leaves on out_*: left, top, crop width and crop height in out_tdata,
// status in out_tuser (1 = nothing to crop).
// Throughput: one pixel per cycle while results drain; the front end only compares
// and counts, the back end folds one queued pixel into the box per cycle.
// out_tvalid rises once the last pixel has passed queue, snapshot and result register.
// A stalled receiver holds the result; the back end keeps folding pixels of the next
// frame and only waits when a second frame end finds the snapshot stage occupied, after
// which the two-entry queue fills and in_tready drops.
// Synchronous active-low reset clears the counters, background, box, queue and result
// valid, and sets both dimensions to 4096.
// Depends on acbb_pkg, acbb_front, acbb_fifo, acbb_back.
module auto_crop_border_box #(
  parameter int Q_DEPTH = acbb_pkg::Q_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Pixel input
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [acbb_pkg::IN_TDATA_W-1:0]      in_tdata,   // red, green, blue
  // Result output
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [acbb_pkg::OUT_TDATA_W-1:0]     out_tdata,  // left, top, crop_width,
                                                           // crop_height, zero pad
  output logic                                 out_tuser,  // status
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acbb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import acbb_pkg::*;

  logic [DIM_W-1:0] img_width_r;
  logic [DIM_W-1:0] img_height_r;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [PIX_W-1:0] pix;
  evt_t             push_evt;
  evt_t             head_evt;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             head_valid;
  logic [CNT_W-1:0] res_left;
  logic [CNT_W-1:0] res_top;
  logic [DIM_W-1:0] res_cw;
  logic [DIM_W-1:0] res_ch;
  logic             res_status;

  assign cfg_ready = 1'b1;

  // Hold frame size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= DIM_W'(MAX_DIM);
      img_height_r <= DIM_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMG_WIDTH:  img_width_r  <= cfg_data[DIM_W-1:0];
        REG_IMG_HEIGHT: img_height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = eff_dim(img_width_r);
  assign h_eff = eff_dim(img_height_r);

  // Pack pixel with red in the top byte for comparison
  assign pix = {in_tdata[CH_W-1:0], in_tdata[2*CH_W-1:CH_W], in_tdata[3*CH_W-1:2*CH_W]};

  acbb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .pix       (pix),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_evt     (push_evt)
  );

  acbb_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_evt   (push_evt),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_evt   (head_evt)
  );

  acbb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_evt   (head_evt),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_left   (res_left),
    .out_top    (res_top),
    .out_cw     (res_cw),
    .out_ch     (res_ch),
    .out_status (res_status)
  );

  // Pack result fields from the lowest bit up
  assign out_tdata = {(OUT_TDATA_W - 2*CNT_W - 2*DIM_W)'(0), res_ch, res_cw, res_top, res_left};
  assign out_tuser = res_status;

endmodule
